// ===== hw/rtl/tti_pkg.sv =====
// Shared types, codes and defaults for the trilinear table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package tti_pkg;

  localparam int unsigned AXIS_POINTS_DEF = 32;
  localparam int unsigned GRID_WORDS_DEF  = 4096;

  localparam int unsigned VAL_W  = 32;  // Q16.16 values
  localparam int unsigned WGT_W  = 16;  // Q0.16 weights
  localparam int unsigned CNT_W  = 6;   // breakpoint counts
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned IDX_W  = 16;  // flattened grid index
  localparam int unsigned DIV_W  = 35;  // divider remainder width

  typedef enum logic [2:0] {
    FUNC_WR_AXIS1 = 3'd0,
    FUNC_WR_AXIS2 = 3'd1,
    FUNC_WR_AXIS3 = 3'd2,
    FUNC_WR_GRID  = 3'd3,
    FUNC_QUERY    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    REG_COUNT_AXIS1 = 2'd0,
    REG_COUNT_AXIS2 = 2'd1,
    REG_COUNT_AXIS3 = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_CHK,
    ST_AX_LO,
    ST_AX_HI,
    ST_AX_SCAN,
    ST_AX_DIV,
    ST_IDX1,
    ST_IDX2,
    ST_G_RD,
    ST_G_CAP,
    ST_B_MUL,
    ST_B_ADD,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/tti_div.sv =====
// Restoring divider: quotient of (num << 16) / den for num < den, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module tti_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tti_pkg::DIV_W-1:0]     num_i,
  input  wire logic [tti_pkg::DIV_W-1:0]     den_i,
  output logic                               done_o,
  output logic [tti_pkg::WGT_W-1:0]          quot_o
);

  logic [tti_pkg::DIV_W-1:0] rem_q, rem_d, den_q, shl;
  logic [tti_pkg::WGT_W-1:0] quot_q, quot_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;

  always_comb begin
    shl    = {rem_q[tti_pkg::DIV_W-2:0], 1'b0};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      quot_d = '0;
      cnt_d  = 5'(tti_pkg::WGT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shl >= den_q) begin
        rem_d  = shl - den_q;
        quot_d = {quot_q[tti_pkg::WGT_W-2:0], 1'b1};
      end else begin
        rem_d  = shl;
        quot_d = {quot_q[tti_pkg::WGT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  // remainder stays below the divisor for the whole run
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q) else $error("divider remainder out of range");
  // no restart mid-division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  // done follows the last iteration
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("spurious divider done");

endmodule
`default_nettype wire

// ===== hw/rtl/trilinear_table_interp_core.sv =====
// Top level of the trilinear table interpolator: stores, sequencer and blend unit.
`timescale 1ns / 1ps
`default_nettype none
// Trilinear lookup over three breakpoint axes and a 3-D grid, all signed Q16.16.
// Write beats (func 0..3) write the addressed store as they are accepted. A
// query beat is worked through by a small sequencer one step at a time: per
// axis a linear breakpoint scan over the axis memory (one read a cycle: a
// count check, which ends it for an axis of fewer than two points, a compare
// with breakpoint zero for a low clamp, one with the last breakpoint for a
// high clamp, then a scan upward from breakpoint one for an interior hit)
// followed by a run of the shared bit-serial divider after an interior hit;
// then two index steps, reads of the eight grid corners (one registered
// port, a read and a capture per corner), seven blends in the shared
// multiply/add blend unit (a multiply and an add each) and a load of the
// output register. The input stalls for the whole of a query; the result
// sits in an output register until taken, and write beats are accepted
// meanwhile. Counts above AXIS_POINTS clamp; a count of zero gives result 0.
// Stores power up undefined and need no clearing.
module trilinear_table_interp_core #(
  parameter int unsigned AXIS_POINTS = tti_pkg::AXIS_POINTS_DEF,
  parameter int unsigned GRID_WORDS  = tti_pkg::GRID_WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [tti_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tti_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [tti_pkg::ADDR_W-1:0]        addr_i,
  input  wire logic signed [tti_pkg::VAL_W-1:0]  value_i,
  input  wire logic signed [tti_pkg::VAL_W-1:0]  q_axis1_i,
  input  wire logic signed [tti_pkg::VAL_W-1:0]  q_axis2_i,
  input  wire logic signed [tti_pkg::VAL_W-1:0]  q_axis3_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [tti_pkg::VAL_W-1:0]       result_o
);

  localparam int unsigned AW = (AXIS_POINTS > 1) ? $clog2(AXIS_POINTS) : 1;
  localparam int unsigned GW = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
  localparam int unsigned CW = tti_pkg::CNT_W;
  localparam int unsigned VW = tti_pkg::VAL_W;
  localparam int unsigned TW = tti_pkg::WGT_W;
  localparam int unsigned XW = tti_pkg::IDX_W;
  localparam int unsigned DW = tti_pkg::DIV_W;
  localparam int unsigned PW = VW + 1 + TW + 1;  // blend product width

  // ---------------- configuration ----------------
  logic [CW-1:0] cnt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= CW'(1);
      cnt_q[1] <= CW'(1);
      cnt_q[2] <= CW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tti_pkg::REG_COUNT_AXIS1: cnt_q[0] <= cfg_wdata_i;
        tti_pkg::REG_COUNT_AXIS2: cnt_q[1] <= cfg_wdata_i;
        tti_pkg::REG_COUNT_AXIS3: cnt_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective counts, clamped to the axis depth
  logic [CW-1:0] n_eff [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n_eff[a] = (32'(cnt_q[a]) > AXIS_POINTS) ? CW'(AXIS_POINTS) : cnt_q[a];
    end
  end

  // ---------------- state ----------------
  tti_pkg::state_e state_q, state_d;

  logic                 accept, out_free;
  logic [1:0]           ax_q;
  logic [CW-1:0]        m_q, seg_q [3];
  logic [TW-1:0]        w_q [3];
  logic signed [VW-1:0] qc_q [3];
  logic signed [VW-1:0] lo_q;
  logic [2:0]           c_q, b_q;
  logic [XW-1:0]        n12_q, row_q [2], base_q [2];
  logic signed [VW-1:0] corner_q [8];
  logic signed [VW-1:0] tmp_q [7];
  logic signed [VW-1:0] fin_q;
  logic                 out_valid_q;
  logic signed [VW-1:0] result_q;

  // current axis view
  logic [CW-1:0]        n_cur;
  logic signed [VW-1:0] q_cur, x_rd;
  logic [CW-1:0]        last;
  logic                 div_done;
  logic [TW-1:0]        div_quot;
  logic                 zero_cnt;

  assign n_cur    = n_eff[ax_q];
  assign q_cur    = qc_q[ax_q];
  assign last     = n_cur - CW'(1);
  assign zero_cnt = (n_eff[0] == '0) || (n_eff[1] == '0) || (n_eff[2] == '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  // ---------------- memories ----------------
  logic [AW-1:0]        ax_raddr;
  logic signed [VW-1:0] ax_rd_q [3];
  logic signed [VW-1:0] ax1_mem [AXIS_POINTS];
  logic signed [VW-1:0] ax2_mem [AXIS_POINTS];
  logic signed [VW-1:0] ax3_mem [AXIS_POINTS];
  logic signed [VW-1:0] grid_mem [GRID_WORDS];
  logic signed [VW-1:0] grid_rd_q;
  logic                 grid_oob_q;
  logic [XW-1:0]        gidx;
  logic                 ax_wr_ok, grid_wr_ok;

  assign ax_wr_ok   = 32'(addr_i) < AXIS_POINTS;
  assign grid_wr_ok = 32'(addr_i) < GRID_WORDS;

  always_ff @(posedge clk_i) begin
    if (accept && ax_wr_ok && func_i == tti_pkg::FUNC_WR_AXIS1) begin
      ax1_mem[AW'(addr_i)] <= value_i;
    end
    ax_rd_q[0] <= ax1_mem[ax_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && ax_wr_ok && func_i == tti_pkg::FUNC_WR_AXIS2) begin
      ax2_mem[AW'(addr_i)] <= value_i;
    end
    ax_rd_q[1] <= ax2_mem[ax_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && ax_wr_ok && func_i == tti_pkg::FUNC_WR_AXIS3) begin
      ax3_mem[AW'(addr_i)] <= value_i;
    end
    ax_rd_q[2] <= ax3_mem[ax_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && grid_wr_ok && func_i == tti_pkg::FUNC_WR_GRID) begin
      grid_mem[GW'(addr_i)] <= value_i;
    end
    grid_rd_q  <= grid_mem[GW'(gidx)];
    grid_oob_q <= 32'(gidx) >= GRID_WORDS;
  end

  assign x_rd = ax_rd_q[ax_q];

  // grid index of the corner in c_q: bit 2 picks the axis-three plane,
  // bit 1 the axis-one row, bit 0 the axis-two column
  logic [CW-1:0] j0, j1;
  assign j0   = seg_q[1];
  assign j1   = (seg_q[1] + CW'(1) < n_eff[1]) ? seg_q[1] + CW'(1) : seg_q[1];
  assign gidx = base_q[c_q[2]] + row_q[c_q[1]] + XW'(c_q[0] ? j1 : j0);

  // ---------------- shared divider ----------------
  logic          div_start;
  logic [DW-1:0] div_num, div_den;

  assign div_num = DW'(signed'({q_cur[VW-1], q_cur}) - signed'({lo_q[VW-1], lo_q}));
  assign div_den = DW'(signed'({x_rd[VW-1], x_rd}) - signed'({lo_q[VW-1], lo_q}));

  tti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------- shared blend unit ----------------
  logic signed [VW-1:0] bl_a, bl_b, bl_a_q;
  logic [TW-1:0]        bl_t;
  logic signed [PW-1:0] prod_q;
  logic signed [VW:0]   diff;
  logic signed [VW+2:0] sum;
  logic signed [VW-1:0] bl_res;

  always_comb begin
    bl_a = corner_q[0];
    bl_b = corner_q[1];
    bl_t = w_q[1];
    case (b_q)
      3'd0: begin bl_a = corner_q[0]; bl_b = corner_q[1]; bl_t = w_q[1]; end
      3'd1: begin bl_a = corner_q[2]; bl_b = corner_q[3]; bl_t = w_q[1]; end
      3'd2: begin bl_a = tmp_q[0];    bl_b = tmp_q[1];    bl_t = w_q[0]; end
      3'd3: begin bl_a = corner_q[4]; bl_b = corner_q[5]; bl_t = w_q[1]; end
      3'd4: begin bl_a = corner_q[6]; bl_b = corner_q[7]; bl_t = w_q[1]; end
      3'd5: begin bl_a = tmp_q[3];    bl_b = tmp_q[4];    bl_t = w_q[0]; end
      3'd6: begin bl_a = tmp_q[2];    bl_b = tmp_q[5];    bl_t = w_q[2]; end
      default: ;
    endcase
  end

  assign diff = signed'({bl_b[VW-1], bl_b}) - signed'({bl_a[VW-1], bl_a});
  // arithmetic shift floors the product
  assign sum  = signed'({{3{bl_a_q[VW-1]}}, bl_a_q}) + signed'(prod_q[PW-1:16]);

  always_comb begin
    if (sum[VW+2:VW-1] == '0 || sum[VW+2:VW-1] == '1) begin
      bl_res = sum[VW-1:0];
    end else if (sum[VW+2]) begin
      bl_res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      bl_res = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      tti_pkg::ST_IDLE:
        if (accept && func_i == tti_pkg::FUNC_QUERY) begin
          state_d = tti_pkg::ST_AX_CHK;
        end
      tti_pkg::ST_AX_CHK:
        if (zero_cnt) begin
          state_d = tti_pkg::ST_DONE;
        end else if (n_cur < CW'(2)) begin
          state_d = (ax_q == 2'd2) ? tti_pkg::ST_IDX1 : tti_pkg::ST_AX_CHK;
        end else begin
          state_d = tti_pkg::ST_AX_LO;
        end
      tti_pkg::ST_AX_LO:
        if (q_cur <= x_rd) begin
          state_d = (ax_q == 2'd2) ? tti_pkg::ST_IDX1 : tti_pkg::ST_AX_CHK;
        end else begin
          state_d = tti_pkg::ST_AX_HI;
        end
      tti_pkg::ST_AX_HI:
        if (q_cur >= x_rd) begin
          state_d = (ax_q == 2'd2) ? tti_pkg::ST_IDX1 : tti_pkg::ST_AX_CHK;
        end else begin
          state_d = tti_pkg::ST_AX_SCAN;
        end
      tti_pkg::ST_AX_SCAN:
        if (x_rd > q_cur || m_q == last) begin
          state_d = tti_pkg::ST_AX_DIV;
        end
      tti_pkg::ST_AX_DIV:
        if (div_done) begin
          state_d = (ax_q == 2'd2) ? tti_pkg::ST_IDX1 : tti_pkg::ST_AX_CHK;
        end
      tti_pkg::ST_IDX1: state_d = tti_pkg::ST_IDX2;
      tti_pkg::ST_IDX2: state_d = tti_pkg::ST_G_RD;
      tti_pkg::ST_G_RD: state_d = tti_pkg::ST_G_CAP;
      tti_pkg::ST_G_CAP:
        state_d = (c_q == 3'd7) ? tti_pkg::ST_B_MUL : tti_pkg::ST_G_RD;
      tti_pkg::ST_B_MUL: state_d = tti_pkg::ST_B_ADD;
      tti_pkg::ST_B_ADD:
        state_d = (b_q == 3'd6) ? tti_pkg::ST_DONE : tti_pkg::ST_B_MUL;
      tti_pkg::ST_DONE:
        if (out_free) begin
          state_d = tti_pkg::ST_IDLE;
        end
      default: state_d = tti_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_stall_o = 1'b1;
    ax_raddr   = '0;
    div_start  = 1'b0;
    case (state_q)
      tti_pkg::ST_IDLE:    in_stall_o = 1'b0;
      tti_pkg::ST_AX_CHK:  ax_raddr = '0;
      tti_pkg::ST_AX_LO:   ax_raddr = AW'(last);
      // scan starts at breakpoint one
      tti_pkg::ST_AX_HI:   ax_raddr = AW'(1);
      tti_pkg::ST_AX_SCAN: begin
        ax_raddr  = AW'(m_q + CW'(1));
        div_start = x_rd > q_cur || m_q == last;
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tti_pkg::ST_IDLE;
      ax_q        <= '0;
      m_q         <= '0;
      c_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        tti_pkg::ST_IDLE: begin
          ax_q <= '0;
          c_q  <= '0;
          b_q  <= '0;
        end
        tti_pkg::ST_AX_CHK:
          if (n_cur < CW'(2)) begin
            ax_q <= ax_q + 2'd1;
          end
        tti_pkg::ST_AX_LO:
          if (q_cur <= x_rd) begin
            ax_q <= ax_q + 2'd1;
          end
        tti_pkg::ST_AX_HI:
          if (q_cur >= x_rd) begin
            ax_q <= ax_q + 2'd1;
          end else begin
            m_q <= CW'(1);
          end
        tti_pkg::ST_AX_SCAN:
          if (!(x_rd > q_cur || m_q == last)) begin
            m_q <= m_q + CW'(1);
          end
        tti_pkg::ST_AX_DIV:
          if (div_done) begin
            ax_q <= ax_q + 2'd1;
          end
        tti_pkg::ST_G_CAP: c_q <= c_q + 3'd1;
        tti_pkg::ST_B_ADD: b_q <= b_q + 3'd1;
        default: ;
      endcase
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == tti_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      tti_pkg::ST_IDLE:
        if (accept) begin
          qc_q[0] <= q_axis1_i;
          qc_q[1] <= q_axis2_i;
          qc_q[2] <= q_axis3_i;
        end
      tti_pkg::ST_AX_CHK: begin
        seg_q[ax_q] <= '0;
        w_q[ax_q]   <= '0;
        fin_q       <= '0;
      end
      tti_pkg::ST_AX_LO: lo_q <= x_rd;
      tti_pkg::ST_AX_HI:
        if (q_cur >= x_rd) begin
          seg_q[ax_q] <= last;
        end
      tti_pkg::ST_AX_SCAN:
        if (x_rd > q_cur || m_q == last) begin
          seg_q[ax_q] <= m_q - CW'(1);
        end else begin
          lo_q <= x_rd;
        end
      tti_pkg::ST_AX_DIV:
        if (div_done) begin
          w_q[ax_q] <= div_quot;
        end
      tti_pkg::ST_IDX1: begin
        n12_q    <= XW'(n_eff[0] * n_eff[1]);
        row_q[0] <= XW'(seg_q[0] * n_eff[1]);
        row_q[1] <= XW'(((seg_q[0] + CW'(1) < n_eff[0]) ? seg_q[0] + CW'(1) : seg_q[0])
                        * n_eff[1]);
      end
      tti_pkg::ST_IDX2: begin
        base_q[0] <= XW'(seg_q[2] * n12_q);
        base_q[1] <= XW'(((seg_q[2] + CW'(1) < n_eff[2]) ? seg_q[2] + CW'(1) : seg_q[2])
                         * n12_q);
      end
      tti_pkg::ST_G_CAP: corner_q[c_q] <= grid_oob_q ? '0 : grid_rd_q;
      tti_pkg::ST_B_MUL: begin
        prod_q <= PW'(diff * signed'({1'b0, bl_t}));
        bl_a_q <= bl_a;
      end
      tti_pkg::ST_B_ADD: begin
        tmp_q[b_q] <= bl_res;
        fin_q      <= bl_res;
      end
      default: ;
    endcase
    if (state_q == tti_pkg::ST_DONE && out_free) begin
      result_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // divider only reports back while the sequencer waits on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tti_pkg::ST_AX_DIV) else $error("unexpected divider done");
  // an accepted query starts the axis search
  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == tti_pkg::FUNC_QUERY |=> state_q == tti_pkg::ST_AX_CHK)
    else $error("query not started");
  // the scan never runs past the last breakpoint in use
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tti_pkg::ST_AX_SCAN |-> m_q <= last && m_q != '0)
    else $error("breakpoint scan out of range");
  // a finished result is never overwritten while still waiting
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tti_pkg::ST_DONE && out_valid_q && out_stall_i
      |=> state_q == tti_pkg::ST_DONE) else $error("result dropped");

endmodule
`default_nettype wire
